// ----- rtl/core/sfs_pkg.sv -----
// Shared types, constants and helper functions of the sprite frame sequencer.
`timescale 1ns / 1ps
`default_nettype none
package sfs_pkg;

    localparam int ANIM_SLOTS  = 16;
    localparam int MAX_FRAMES  = 64;
    localparam int ANIM_W      = 4;
    localparam int FRAME_W     = 6;
    localparam int HOLD_DEPTH  = ANIM_SLOTS * MAX_FRAMES;
    localparam int HOLD_AW     = ANIM_W + FRAME_W;
    localparam int CATCHUP     = 1024;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_DESC  = 3'd1;
    localparam logic [2:0] CMD_HOLD  = 3'd2;
    localparam logic [2:0] CMD_START = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    localparam logic [1:0] MODE_LR   = 2'd0;
    localparam logic [1:0] MODE_RL   = 2'd1;
    localparam logic [1:0] MODE_BF   = 2'd2;
    localparam logic [1:0] MODE_RAND = 2'd3;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_DESC  = 3'd1,
        OP_HOLD  = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4,
        OP_NONE  = 3'd5
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [31:0]        elapsed;
        logic [ANIM_W-1:0]  anim;
        logic [FRAME_W-1:0] frame;
        logic [11:0]        bx;
        logic [11:0]        by;
        logic [11:0]        stride;
        logic [7:0]         value;
        logic [6:0]         count;
        logic [31:0]        delay;
        logic [1:0]         mode;
        logic [8:0]         loops;
        logic [4:0]         next;
    } t_item;

    typedef struct packed {
        logic [11:0] bx;
        logic [11:0] by;
        logic [11:0] stride;
        logic [6:0]  count;
        logic [31:0] delay;
        logic [1:0]  mode;
        logic [8:0]  loops;
        logic [4:0]  next;
    } t_desc;

    typedef struct packed {
        logic clearing;
        logic deq;
    } t_stat;

    // displayed slot for a frame counter value
    function automatic logic [7:0] slot_of(input logic [6:0] count, input logic [1:0] mode,
                                           input logic [7:0] cfr);
        logic [7:0] n;
        logic [7:0] n2;
        logic [7:0] r;
        n  = {1'b0, count};
        n2 = {count, 1'b0};
        if (mode == MODE_LR || (mode == MODE_BF && cfr < n)) begin
            r = cfr;
        end else if (mode == MODE_RL || mode == MODE_RAND) begin
            r = (cfr < n) ? (n - cfr - 8'd1) : 8'd0;
        end else begin
            r = (cfr < n2) ? (n2 - cfr - 8'd1) : 8'd0;
        end
        return r;
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] l);
        logic [15:0] r;
        r = l >> 1;
        if (l[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/sfs_front.sv -----
// Front end: accepts items, decodes the command and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module sfs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic [2:0]    i_cmd,
    input  wire logic [31:0]   i_elapsed,
    input  wire logic [3:0]    i_anim_index,
    input  wire logic [5:0]    i_frame_index,
    input  wire logic [11:0]   i_base_x,
    input  wire logic [11:0]   i_base_y,
    input  wire logic [11:0]   i_frame_stride,
    input  wire logic [7:0]    i_count_value,
    input  wire logic [31:0]   i_frame_delay,
    input  wire logic [1:0]    i_browse_mode,
    input  wire logic [8:0]    i_loop_limit,
    input  wire logic [4:0]    i_next_anim,
    output logic               o_valid,
    output sfs_pkg::t_item     o_item,
    input  wire logic          i_deq
);
    sfs_pkg::t_item r_q [sfs_pkg::QUEUE_DEPTH];
    logic [sfs_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [sfs_pkg::QUEUE_AW:0]   r_cnt;
    sfs_pkg::t_item n_item;
    logic wr, rd;

    always_comb begin
        n_item         = '0;
        n_item.elapsed = i_elapsed;
        n_item.anim    = i_anim_index;
        n_item.frame   = i_frame_index;
        n_item.bx      = i_base_x;
        n_item.by      = i_base_y;
        n_item.stride  = i_frame_stride;
        n_item.value   = i_count_value;
        n_item.count   = (i_count_value > 8'(sfs_pkg::MAX_FRAMES)) ?
                         7'(sfs_pkg::MAX_FRAMES) : i_count_value[6:0];
        n_item.delay   = (i_frame_delay == 32'd0) ? 32'd1 : i_frame_delay;
        n_item.mode    = i_browse_mode;
        n_item.loops   = i_loop_limit;
        n_item.next    = i_next_anim;
        case (i_cmd)
            sfs_pkg::CMD_TICK:  n_item.op = sfs_pkg::OP_TICK;
            sfs_pkg::CMD_DESC:  n_item.op = sfs_pkg::OP_DESC;
            sfs_pkg::CMD_HOLD:  n_item.op = sfs_pkg::OP_HOLD;
            sfs_pkg::CMD_START: n_item.op = sfs_pkg::OP_START;
            sfs_pkg::CMD_STOP:  n_item.op = sfs_pkg::OP_STOP;
            default:            n_item.op = sfs_pkg::OP_NONE;
        endcase
    end

    assign o_full  = (r_cnt == (sfs_pkg::QUEUE_AW+1)'(sfs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_deq && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            if (wr && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/sfs_mod.sv -----
// Iterative remainder unit: 16-bit value modulo a 7-bit count, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module sfs_mod (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_num,
    input  wire logic [6:0]  i_den,
    output logic             o_done,
    output logic [6:0]       o_rem
);
    logic        r_busy;
    logic [3:0]  r_bit;
    logic [15:0] r_num;
    logic [6:0]  r_den;
    logic [6:0]  r_rem;
    logic [7:0]  shifted;
    logic [7:0]  trial;

    assign shifted = {r_rem, r_num[15]};
    assign trial   = (shifted >= {1'b0, r_den}) ? (shifted - {1'b0, r_den}) : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= trial[6:0];
                r_num <= {r_num[14:0], 1'b0};
                r_bit <= r_bit + 1'b1;
                if (r_bit == 4'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem;
endmodule
`default_nettype wire

// ----- rtl/core/sfs_back.sv -----
// Back end: descriptor store, hold table, frame-advance sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module sfs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire sfs_pkg::t_item i_item,
    output logic               o_deq,
    output sfs_pkg::t_stat     o_stat,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [19:0]        o_sprite_x,
    output logic [11:0]        o_sprite_y,
    output logic               o_active,
    output logic [3:0]         o_anim_now,
    output logic [6:0]         o_frame_now
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_HOLD  = 8'b0000_1000,
        S_MOD   = 8'b0001_0000,
        S_ADV   = 8'b0010_0000,
        S_XY    = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    sfs_pkg::t_desc r_desc [sfs_pkg::ANIM_SLOTS];
    sfs_pkg::t_desc d;

    logic [sfs_pkg::ANIM_W-1:0] r_cur, n_cur;
    logic        r_running, n_running, r_stopped, n_stopped;
    logic [6:0]  r_fc, n_fc;
    logic [7:0]  r_hc, n_hc, r_lc, n_lc;
    logic [32:0] r_accum, n_accum;
    logic [5:0]  r_rand, n_rand;
    logic [15:0] r_lfsr, n_lfsr;
    logic [19:0] r_x, n_x;
    logic [11:0] r_y, n_y;
    logic [10:0] r_steps, n_steps;
    logic        r_idx_ok, n_idx_ok;
    logic [sfs_pkg::HOLD_AW-1:0] r_clr;
    logic        r_out_valid;

    logic        desc_we;
    logic        ram_we;
    logic [sfs_pkg::HOLD_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic        mod_start, mod_done;
    logic [6:0]  mod_rem;

    logic [32:0] delay33;
    logic [7:0]  idx, frep, limit, cfr, slot;
    logic [19:0] prod;

    assign d       = r_desc[r_cur];
    assign delay33 = {1'b0, d.delay};
    assign idx     = (d.mode == sfs_pkg::MODE_BF) ?
                     sfs_pkg::slot_of(d.count, d.mode, {1'b0, r_fc}) : {1'b0, r_fc};
    assign frep    = r_idx_ok ? ram_rdata : 8'd1;
    assign limit   = (d.mode == sfs_pkg::MODE_BF) ? {d.count, 1'b0} : {1'b0, d.count};
    assign cfr     = (d.mode == sfs_pkg::MODE_RAND) ? {2'b00, r_rand} : {1'b0, r_fc};
    assign slot    = sfs_pkg::slot_of(d.count, d.mode, cfr);
    assign prod    = {8'd0, d.stride} * {12'd0, slot};
    assign ram_raddr = {r_cur, idx[sfs_pkg::FRAME_W-1:0]};

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_running = r_running;
        n_stopped = r_stopped;
        n_fc      = r_fc;
        n_hc      = r_hc;
        n_lc      = r_lc;
        n_accum   = r_accum;
        n_rand    = r_rand;
        n_lfsr    = r_lfsr;
        n_x       = r_x;
        n_y       = r_y;
        n_steps   = r_steps;
        n_idx_ok  = r_idx_ok;
        o_deq     = 1'b0;
        desc_we   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {i_item.anim, i_item.frame};
        ram_wdata = i_item.value;
        mod_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 8'hFF;
                if (r_clr == sfs_pkg::HOLD_AW'(sfs_pkg::HOLD_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && !r_out_valid) begin
                    o_deq   = 1'b1;
                    n_state = S_DONE;
                    case (i_item.op)
                        sfs_pkg::OP_TICK: begin
                            if (!r_running || r_stopped) begin
                                n_accum = '0;
                            end else begin
                                n_accum = r_accum + {1'b0, i_item.elapsed};
                                n_steps = '0;
                                n_state = S_CHECK;
                            end
                        end
                        sfs_pkg::OP_DESC: desc_we = 1'b1;
                        sfs_pkg::OP_HOLD: ram_we  = 1'b1;
                        sfs_pkg::OP_START: begin
                            n_cur     = i_item.anim;
                            n_running = 1'b1;
                            n_stopped = 1'b0;
                            n_fc      = '0;
                            n_hc      = '0;
                            n_lc      = '0;
                            n_accum   = '0;
                        end
                        sfs_pkg::OP_STOP: n_stopped = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (r_accum > delay33) begin
                    if (r_steps == 11'(sfs_pkg::CATCHUP)) begin
                        n_accum = delay33;
                        n_state = S_XY;
                    end else begin
                        n_steps  = r_steps + 1'b1;
                        n_accum  = r_accum - delay33;
                        n_idx_ok = (idx < 8'(sfs_pkg::MAX_FRAMES));
                        n_state  = S_HOLD;
                    end
                end else begin
                    n_state = S_XY;
                end
            end
            S_HOLD: begin
                if (({1'b0, r_hc} + 9'd1) < {1'b0, frep}) begin
                    n_hc    = r_hc + 1'b1;
                    n_state = S_CHECK;
                end else begin
                    n_hc   = '0;
                    n_lfsr = sfs_pkg::lfsr_next(r_lfsr);
                    if (d.count == '0) begin
                        n_rand  = '0;
                        n_state = S_ADV;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_rand  = mod_rem[5:0];
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                n_state = S_CHECK;
                if (({1'b0, r_fc} + 8'd1) < limit) begin
                    n_fc = r_fc + 1'b1;
                end else begin
                    n_fc = '0;
                    if (!d.loops[8] && (({1'b0, r_lc} + 9'd1) < d.loops)) begin
                        n_lc = r_lc + 1'b1;
                    end else begin
                        n_lc = '0;
                        if (d.next[4]) begin
                            n_fc      = (d.count != '0) ? d.count - 1'b1 : '0;
                            n_running = 1'b0;
                            n_state   = S_XY;
                        end else begin
                            n_cur = d.next[sfs_pkg::ANIM_W-1:0];
                        end
                    end
                end
            end
            S_XY: begin
                n_x     = {8'd0, d.bx} + prod;
                n_y     = d.by;
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (desc_we) begin
            r_desc[i_item.anim] <= '{bx: i_item.bx, by: i_item.by, stride: i_item.stride,
                                     count: i_item.count, delay: i_item.delay,
                                     mode: i_item.mode, loops: i_item.loops,
                                     next: i_item.next};
        end
        r_idx_ok <= n_idx_ok;
        r_steps  <= n_steps;
        if (r_state == S_DONE) begin
            o_sprite_x  <= r_x;
            o_sprite_y  <= r_y;
            o_active    <= r_running && !r_stopped;
            o_anim_now  <= r_cur;
            o_frame_now <= r_fc;
        end
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cur       <= '0;
            r_running   <= 1'b0;
            r_stopped   <= 1'b0;
            r_fc        <= '0;
            r_hc        <= '0;
            r_lc        <= '0;
            r_accum     <= '0;
            r_rand      <= '0;
            r_lfsr      <= sfs_pkg::LFSR_SEED;
            r_x         <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= (r_state == S_CLEAR) ? r_clr + 1'b1 : r_clr;
            r_cur     <= n_cur;
            r_running <= n_running;
            r_stopped <= n_stopped;
            r_fc      <= n_fc;
            r_hc      <= n_hc;
            r_lc      <= n_lc;
            r_accum   <= n_accum;
            r_rand    <= n_rand;
            r_lfsr    <= n_lfsr;
            r_x       <= n_x;
            r_y       <= n_y;
            if (r_state == S_DONE) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    sfs_ram #(.WIDTH(8), .DEPTH(sfs_pkg::HOLD_DEPTH)) u_hold (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sfs_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_num   (n_lfsr),
        .i_den   (d.count),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign o_empty = !r_out_valid;
    assign o_stat  = '{clearing: (r_state == S_CLEAR), deq: o_deq};
endmodule
`default_nettype wire

// ----- rtl/core/sprite_frame_sequencer.sv -----
// Top level of the sprite frame sequencer: front queue, back sequencer, checks.
//
//  channel   handshake          payload
//  input     push / full        i_cmd .. i_next_anim
//  result    empty / pop        o_sprite_x .. o_frame_now
//
// One result per item; writes, start, stop and idle ticks go from S_IDLE to S_DONE.
// A running tick visits S_CHECK, S_HOLD per delay step, plus S_MOD (LFSR modulo unit,
// one bit a cycle; skipped at frame count zero), S_ADV per advance, then S_XY, S_DONE;
// steps capped at 1024 per tick. After reset the hold table is set to 255 while items
// queue, up to 4 ahead of the sequencer; a waiting result blocks only the back end.
`timescale 1ns / 1ps
`default_nettype none
module sprite_frame_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_elapsed,
    input  wire logic [3:0]  i_anim_index,
    input  wire logic [5:0]  i_frame_index,
    input  wire logic [11:0] i_base_x,
    input  wire logic [11:0] i_base_y,
    input  wire logic [11:0] i_frame_stride,
    input  wire logic [7:0]  i_count_value,
    input  wire logic [31:0] i_frame_delay,
    input  wire logic [1:0]  i_browse_mode,
    input  wire logic [8:0]  i_loop_limit,
    input  wire logic [4:0]  i_next_anim,
    output logic             empty,
    input  wire logic        pop,
    output logic [19:0]      o_sprite_x,
    output logic [11:0]      o_sprite_y,
    output logic             o_active,
    output logic [3:0]       o_anim_now,
    output logic [6:0]       o_frame_now
);
    logic           q_valid, deq;
    sfs_pkg::t_item q_item;
    sfs_pkg::t_stat stat;

    sfs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_cmd          (i_cmd),
        .i_elapsed      (i_elapsed),
        .i_anim_index   (i_anim_index),
        .i_frame_index  (i_frame_index),
        .i_base_x       (i_base_x),
        .i_base_y       (i_base_y),
        .i_frame_stride (i_frame_stride),
        .i_count_value  (i_count_value),
        .i_frame_delay  (i_frame_delay),
        .i_browse_mode  (i_browse_mode),
        .i_loop_limit   (i_loop_limit),
        .i_next_anim    (i_next_anim),
        .o_valid        (q_valid),
        .o_item         (q_item),
        .i_deq          (deq)
    );

    sfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_deq       (deq),
        .o_stat      (stat),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_sprite_x  (o_sprite_x),
        .o_sprite_y  (o_sprite_y),
        .o_active    (o_active),
        .o_anim_now  (o_anim_now),
        .o_frame_now (o_frame_now)
    );

    // no item leaves the queue during the hold-table fill
    a_no_deq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !stat.deq) else $error("item taken during clear");

    // the back end only dequeues what is there
    a_deq_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq |-> q_valid) else $error("dequeue from empty queue");

    // a waiting result is not dropped
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("result lost");

    // nothing starts while a result still waits
    a_no_deq_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !deq) else $error("item started over waiting result");
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sprite frame sequencer: directed and random items.
`timescale 1ns / 1ps
module tb_top;

    // command code outside the defined set
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] elapsed;
        logic [3:0]  anim;
        logic [5:0]  frame;
        logic [11:0] bx;
        logic [11:0] by;
        logic [11:0] stride;
        logic [7:0]  value;
        logic [31:0] delay;
        logic [1:0]  mode;
        logic [8:0]  loops;
        logic [4:0]  next;
    } t_stim;

    typedef struct {
        logic [19:0] x;
        logic [11:0] y;
        logic        active;
        logic [3:0]  anim;
        logic [6:0]  frame;
    } t_sprite;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    logic    full;
    logic    empty;
    t_stim   drv = '{default: '0};
    t_sprite got;

    t_stim   pending_q[$];
    t_sprite sprite_q[$];

    // predictor state
    int unsigned     d_bx[sfs_pkg::ANIM_SLOTS], d_by[sfs_pkg::ANIM_SLOTS];
    int unsigned     d_stride[sfs_pkg::ANIM_SLOTS], d_count[sfs_pkg::ANIM_SLOTS];
    int unsigned     d_delay[sfs_pkg::ANIM_SLOTS], d_mode[sfs_pkg::ANIM_SLOTS];
    int              d_loops[sfs_pkg::ANIM_SLOTS], d_next[sfs_pkg::ANIM_SLOTS];
    int unsigned     hold_tab[sfs_pkg::HOLD_DEPTH];
    int unsigned     cur_anim, frame_ctr, hold_ctr, loop_ctr, rand_frame;
    logic [15:0]     lfsr_q;
    longint unsigned accum;
    bit              running, stopped;
    logic [19:0]     last_x;
    logic [11:0]     last_y;

    int n_sent, n_got, n_err, n_adv, n_ticks, hold_left;
    bit pressure_done;

    sprite_frame_sequencer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (drv.cmd),
        .i_elapsed      (drv.elapsed),
        .i_anim_index   (drv.anim),
        .i_frame_index  (drv.frame),
        .i_base_x       (drv.bx),
        .i_base_y       (drv.by),
        .i_frame_stride (drv.stride),
        .i_count_value  (drv.value),
        .i_frame_delay  (drv.delay),
        .i_browse_mode  (drv.mode),
        .i_loop_limit   (drv.loops),
        .i_next_anim    (drv.next),
        .empty          (empty),
        .pop            (pop),
        .o_sprite_x     (got.x),
        .o_sprite_y     (got.y),
        .o_active       (got.active),
        .o_anim_now     (got.anim),
        .o_frame_now    (got.frame)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned shown_slot(int unsigned a, int unsigned cfr);
        int unsigned n;
        n = d_count[a];
        if (d_mode[a] == sfs_pkg::MODE_LR || (d_mode[a] == sfs_pkg::MODE_BF && cfr < n))
            return cfr;
        if (d_mode[a] == sfs_pkg::MODE_RL || d_mode[a] == sfs_pkg::MODE_RAND)
            return (cfr < n) ? n - cfr - 1 : 0;
        return (cfr < 2 * n) ? 2 * n - cfr - 1 : 0;
    endfunction

    task automatic run_frames(input logic [31:0] dt);
        longint unsigned dly;
        int unsigned     steps, idx, frep, lim, cfr, a;
        steps = 0;
        if (!running || stopped) begin
            accum = 0;
            return;
        end
        accum += dt;
        a = cur_anim;
        dly = d_delay[a] != 0 ? d_delay[a] : 1;
        while (accum > dly) begin
            if (steps == sfs_pkg::CATCHUP) begin
                accum = dly;
                break;
            end
            steps++;
            accum -= dly;
            idx = (d_mode[a] == sfs_pkg::MODE_BF) ? shown_slot(a, frame_ctr) : frame_ctr;
            frep = (idx < sfs_pkg::MAX_FRAMES) ? hold_tab[a * sfs_pkg::MAX_FRAMES + idx] : 1;
            hold_ctr++;
            if (hold_ctr < frep) continue;
            hold_ctr = 0;
            n_adv++;
            lfsr_q = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? sfs_pkg::LFSR_TAPS : 16'h0);
            rand_frame = d_count[a] != 0 ? lfsr_q % d_count[a] : 0;
            lim = d_count[a] * (d_mode[a] == sfs_pkg::MODE_BF ? 2 : 1);
            frame_ctr++;
            if (frame_ctr < lim) continue;
            frame_ctr = 0;
            if (d_loops[a] >= 0) begin
                loop_ctr++;
                if (int'(loop_ctr) < d_loops[a]) continue;
            end
            loop_ctr = 0;
            if (d_next[a] < 0) begin
                frame_ctr = d_count[a] != 0 ? d_count[a] - 1 : 0;
                running = 0;
                break;
            end
            a = d_next[a] % sfs_pkg::ANIM_SLOTS;
            cur_anim = a;
            dly = d_delay[a] != 0 ? d_delay[a] : 1;
        end
        cfr = (d_mode[a] == sfs_pkg::MODE_RAND) ? rand_frame : frame_ctr;
        last_x = 20'(d_bx[a] + d_stride[a] * shown_slot(a, cfr));
        last_y = d_by[a][11:0];
    endtask

    task automatic step_sequencer(input t_stim it);
        t_sprite e;
        case (it.cmd)
            sfs_pkg::CMD_TICK: begin
                n_ticks++;
                run_frames(it.elapsed);
            end
            sfs_pkg::CMD_DESC: begin
                d_bx[it.anim]     = it.bx;
                d_by[it.anim]     = it.by;
                d_stride[it.anim] = it.stride;
                d_count[it.anim]  = it.value > sfs_pkg::MAX_FRAMES ? sfs_pkg::MAX_FRAMES
                                                                   : int'(it.value);
                d_delay[it.anim]  = it.delay;
                d_mode[it.anim]   = it.mode;
                d_loops[it.anim]  = $signed(it.loops);
                d_next[it.anim]   = $signed(it.next);
            end
            sfs_pkg::CMD_HOLD: hold_tab[it.anim * sfs_pkg::MAX_FRAMES + it.frame] = it.value;
            sfs_pkg::CMD_START: begin
                cur_anim  = it.anim;
                running   = 1;
                stopped   = 0;
                frame_ctr = 0;
                hold_ctr  = 0;
                loop_ctr  = 0;
                accum     = 0;
            end
            sfs_pkg::CMD_STOP: stopped = 1;
            default: ;
        endcase
        e.x      = last_x;
        e.y      = last_y;
        e.active = running && !stopped;
        e.anim   = cur_anim[3:0];
        e.frame  = frame_ctr[6:0];
        sprite_q.push_back(e);
    endtask

    task automatic report(input string what, input int unsigned g, input int unsigned w);
        n_err++;
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, g, w);
    endtask

    function automatic bit quiet_window();
        return n_sent >= 300 && n_sent < 450;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                step_sequencer(drv);
                n_sent++;
            end
            if (!push || !full) begin
                if (pending_q.size() > 0 && (quiet_window() || $urandom_range(99) >= 9)) begin
                    drv  <= pending_q.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                n_got++;
                if (sprite_q.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    t_sprite w;
                    w = sprite_q.pop_front();
                    if (got.x !== w.x) report("sprite_x", got.x, w.x);
                    if (got.y !== w.y) report("sprite_y", got.y, w.y);
                    if (got.active !== w.active) report("active", got.active, w.active);
                    if (got.anim !== w.anim) report("anim_now", got.anim, w.anim);
                    if (got.frame !== w.frame) report("frame_now", got.frame, w.frame);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (n_got >= 400 && !pressure_done) begin
                // long back-pressure so the input side fills up
                pressure_done = 1;
                hold_left = 300;
                pop <= 1'b0;
            end else begin
                pop <= quiet_window() || $urandom_range(99) >= 9;
            end
        end
    end

    function automatic t_stim rand_item(input logic [2:0] c);
        t_stim it;
        it.cmd     = c;
        it.elapsed = $urandom_range(4 << 16);
        it.anim    = 4'($urandom);
        it.frame   = 6'($urandom);
        it.bx      = 12'($urandom);
        it.by      = 12'($urandom);
        it.stride  = 12'($urandom);
        it.value   = 8'($urandom);
        it.delay   = $urandom;
        it.mode    = 2'($urandom);
        it.loops   = 9'($urandom);
        it.next    = 5'($urandom);
        return it;
    endfunction

    function automatic t_stim rand_desc(input int unsigned a);
        t_stim it;
        it       = rand_item(sfs_pkg::CMD_DESC);
        it.anim  = 4'(a);
        it.value = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
        it.delay = ($urandom_range(19) == 0) ? 32'($urandom) : 32'($urandom_range(1, 8) << 14);
        if ($urandom_range(3) != 0) it.loops = 9'($signed($urandom_range(0, 4)) - 1);
        return it;
    endfunction

    initial begin
        t_stim it;
        int    r;
        for (int i = 0; i < sfs_pkg::HOLD_DEPTH; i++) hold_tab[i] = 255;
        for (int i = 0; i < sfs_pkg::ANIM_SLOTS; i++) begin
            d_bx[i] = 0; d_by[i] = 0; d_stride[i] = 0; d_count[i] = 0;
            d_delay[i] = 0; d_mode[i] = 0; d_loops[i] = 0; d_next[i] = 0;
        end
        cur_anim = 0; frame_ctr = 0; hold_ctr = 0; loop_ctr = 0; rand_frame = 0;
        lfsr_q = sfs_pkg::LFSR_SEED; accum = 0; running = 0; stopped = 0;
        last_x = '0; last_y = '0;

        // tick while idle, then every descriptor written, some with edge values
        pending_q.push_back(rand_item(sfs_pkg::CMD_TICK));
        for (int a = 0; a < sfs_pkg::ANIM_SLOTS; a++) begin
            it       = rand_desc(a);
            it.mode  = 2'(a % 4);
            it.value = (a == 1) ? 8'd0 : (a == 2) ? 8'd64 : (a == 6) ? 8'd255 : it.value;
            it.delay = (a == 3) ? 32'd0 : (a == 15) ? 32'hFFFF_FFFF : it.delay;
            it.loops = (a == 4) ? 9'h100 : (a == 5) ? 9'h0FF : (a == 7) ? 9'h1FF : it.loops;
            it.next  = (a == 0) ? 5'h1F : (a == 8) ? 5'h10 : (a == 9) ? 5'h0F : it.next;
            it.bx    = (a == 10) ? 12'hFFF : (a == 11) ? 12'h000 : it.bx;
            it.stride = (a == 10) ? 12'hFFF : it.stride;
            pending_q.push_back(it);
        end
        it = rand_item(sfs_pkg::CMD_HOLD);
        it.anim = 4'd0; it.frame = 6'd0; it.value = 8'd0;
        pending_q.push_back(it);
        it = rand_item(sfs_pkg::CMD_HOLD);
        it.anim = 4'd15; it.frame = 6'd63; it.value = 8'd255;
        pending_q.push_back(it);
        it = rand_item(sfs_pkg::CMD_START); it.anim = 4'd0; pending_q.push_back(it);
        it = rand_item(sfs_pkg::CMD_TICK); it.elapsed = 32'd0; pending_q.push_back(it);
        // catch-up cap
        it = rand_item(sfs_pkg::CMD_TICK); it.elapsed = 32'hFFFF_FFFF; pending_q.push_back(it);
        pending_q.push_back(rand_item(sfs_pkg::CMD_STOP));
        pending_q.push_back(rand_item(sfs_pkg::CMD_TICK));
        it = rand_item(CMD_UNUSED); it.anim = 4'hF; pending_q.push_back(it);
        it = rand_item(sfs_pkg::CMD_START); it.anim = 4'd3; pending_q.push_back(it);
        it = rand_item(sfs_pkg::CMD_TICK); it.elapsed = 32'd5; pending_q.push_back(it);

        for (int n = 0; n < 900; n++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                it = rand_item(sfs_pkg::CMD_TICK);
                if ($urandom_range(49) == 0) it.elapsed = $urandom;
            end else if (r < 55) begin
                it = rand_desc($urandom_range(sfs_pkg::ANIM_SLOTS - 1));
            end else if (r < 80) begin
                it = rand_item(sfs_pkg::CMD_HOLD);
                if ($urandom_range(3) != 0) begin
                    it.frame = 6'($urandom_range(7));
                    it.value = 8'($urandom_range(3));
                end
            end else if (r < 90) begin
                it = rand_item(sfs_pkg::CMD_START);
            end else if (r < 95) begin
                it = rand_item(sfs_pkg::CMD_STOP);
            end else begin
                it = rand_item(3'($urandom_range(int'(sfs_pkg::CMD_STOP) + 1,
                                                 int'(CMD_UNUSED))));
            end
            pending_q.push_back(it);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() > 0 || push || sprite_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d items (%0d ticks), checked %0d results, %0d mismatches",
                 n_sent, n_ticks, n_got, n_err);
        $display("Predicted %0d frame advances across all animations", n_adv);
        if (n_err == 0 && sprite_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Timed out with %0d results outstanding", sprite_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
